[src/dca_pkg.sv]
`timescale 1ns / 1ps
// Package for the drive current arbiter: widths, register indexes, reset values,
// packet kind codes and the configuration register bundle. No dependencies.
package dca_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CUR_W          = 16;
    localparam int THR_W          = 8;
    localparam int ELAPSED_W      = 8;
    localparam int KIND_W         = 3;
    localparam int DISP_W         = CUR_W + 1;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int PROD_W         = CUR_W + THR_W;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_CURRENT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_CURRENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COAST_CURRENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_CURRENT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_LOW       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_HIGH      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INTERLOCK_MS  = 3'd6;

    localparam logic [CUR_W-1:0] RST_MAX_CURRENT   = 16'd35000;
    localparam logic [CUR_W-1:0] RST_BRAKE_CURRENT = 16'd20000;
    localparam logic [CUR_W-1:0] RST_COAST_CURRENT = 16'd5000;
    localparam logic [CUR_W-1:0] RST_SAFE_CURRENT  = 16'd10000;
    localparam logic [THR_W-1:0] RST_CAL_LOW       = 8'd15;
    localparam logic [THR_W-1:0] RST_CAL_HIGH      = 8'd250;
    localparam logic [CUR_W-1:0] RST_INTERLOCK_MS  = 16'd500;

    localparam logic [KIND_W-1:0] KIND_M1_CURRENT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_M1_BRAKE     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_M2_CURRENT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_M2_BRAKE     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_M1_TELEMETRY = 3'd4;
    localparam logic [KIND_W-1:0] KIND_M2_TELEMETRY = 3'd5;

    localparam logic [1:0] SLOT_M1     = 2'd0;
    localparam logic [1:0] SLOT_M2     = 2'd1;
    localparam logic [1:0] SLOT_TELE_1 = 2'd2;

    typedef struct packed {
        logic [CUR_W-1:0] drive_full_ma;
        logic [CUR_W-1:0] brake_hold_ma;
        logic [CUR_W-1:0] coast_hold_ma;
        logic [CUR_W-1:0] stop_hold_ma;
        logic [THR_W-1:0] thr_zero_pt;
        logic [THR_W-1:0] thr_full_pt;
        logic [CUR_W-1:0] interlock_ms;
    } t_cfg;

endpackage

[src/dca_cfg_regs.sv]
`timescale 1ns / 1ps
// Configuration register file of the drive current arbiter.
// Depends on dca_pkg for indexes, reset values and the register bundle type.
module dca_cfg_regs import dca_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_full_ma <= RST_MAX_CURRENT;
            r_cfg.brake_hold_ma <= RST_BRAKE_CURRENT;
            r_cfg.coast_hold_ma <= RST_COAST_CURRENT;
            r_cfg.stop_hold_ma  <= RST_SAFE_CURRENT;
            r_cfg.thr_zero_pt   <= RST_CAL_LOW;
            r_cfg.thr_full_pt   <= RST_CAL_HIGH;
            r_cfg.interlock_ms  <= RST_INTERLOCK_MS;
        end else if (i_wr) begin
            case (i_index)
                REG_MAX_CURRENT:   r_cfg.drive_full_ma <= i_data[CUR_W-1:0];
                REG_BRAKE_CURRENT: r_cfg.brake_hold_ma <= i_data[CUR_W-1:0];
                REG_COAST_CURRENT: r_cfg.coast_hold_ma <= i_data[CUR_W-1:0];
                REG_SAFE_CURRENT:  r_cfg.stop_hold_ma  <= i_data[CUR_W-1:0];
                REG_CAL_LOW:       r_cfg.thr_zero_pt   <= i_data[THR_W-1:0];
                REG_CAL_HIGH:      r_cfg.thr_full_pt   <= i_data[THR_W-1:0];
                REG_INTERLOCK_MS:  r_cfg.interlock_ms  <= i_data[CUR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/dca_divider.sv]
`timescale 1ns / 1ps
// Restoring divider of the drive current arbiter, one quotient bit per cycle.
// Depends on dca_pkg only for the default widths.
module dca_divider import dca_pkg::*; #(
    parameter int DIVIDEND_W = PROD_W,
    parameter int DIVISOR_W  = THR_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_div;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DIVISOR_W:0]    w_shift;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_ge;
    logic [DIVISOR_W-1:0]  n_rem;

    always_comb begin
        w_shift = {r_rem, r_quo[DIVIDEND_W-1]};
        w_ge    = (w_shift >= {1'b0, r_div});
        w_diff  = w_shift - {1'b0, r_div};
        n_rem   = w_ge ? w_diff[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[src/drive_current_arbiter_top.sv]
`timescale 1ns / 1ps
// Top level of the drive current arbiter: tick sequencer, interlock state and
// output register. Depends on dca_pkg, dca_cfg_regs and dca_divider.
//
// One tick word in gives one packet word out. A tick whose throttle lies above
// the low calibration point, with the high point above the low one, goes from
// acceptance to a loaded output register in steps: the throttle-span multiply,
// the load of the shared divider, its one-bit-per-cycle restoring division of
// the 24-bit dividend, the capture of the quotient and the forming of the
// packet. Any other tick goes straight to forming the packet. The input stalls
// while a tick is in work, so the next tick is taken in the cycle after the
// packet is loaded at the earliest; a finished packet waits in the output
// register while the next tick is taken, and a stalled output holds the
// sequencer before the load. Configuration writes are always ready.
module drive_current_arbiter_top import dca_pkg::*; #(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [THR_W-1:0]      i_throttle_raw,
    input  logic                  i_dead_man_pressed,
    input  logic                  i_brake_pressed,
    input  logic                  i_drive_active,
    input  logic                  i_battery_ok,
    input  logic [ELAPSED_W-1:0]  i_elapsed_ms,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [KIND_W-1:0]     o_packet_kind,
    output logic [CUR_W-1:0]      o_command_ma,
    output logic signed [DISP_W-1:0] o_display_ma,
    output logic                  o_interlock_active,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CMP_W = (TIMER_BITS > CUR_W) ? TIMER_BITS : CUR_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FINISH
    } t_state;

    t_cfg                  w_cfg;
    t_state                r_state;
    logic [1:0]            r_slot;
    logic                  r_dm_prev;
    logic                  r_interlock;
    logic [TIMER_BITS-1:0] r_timer;
    logic [THR_W-1:0]      r_raw;
    logic                  r_dm;
    logic                  r_brk;
    logic                  r_active;
    logic                  r_batt;
    logic [PROD_W-1:0]     r_prod;
    logic [CUR_W-1:0]      r_drive;
    logic                  r_out_valid;
    logic [KIND_W-1:0]     r_kind;
    logic [CUR_W-1:0]      r_cmd;
    logic [DISP_W-1:0]     r_disp;
    logic                  r_il_out;

    logic                  w_accept;
    logic                  w_out_take;
    logic                  w_load_out;
    logic [TIMER_BITS:0]   w_sum;
    logic [TIMER_BITS-1:0] w_timer_sat;
    logic [TIMER_BITS-1:0] w_timer_a;
    logic                  w_il_a;
    logic                  w_dm_edge;
    logic                  w_at_zero;
    logic [TIMER_BITS-1:0] n_timer;
    logic                  n_interlock;
    logic                  w_span_ok;
    logic [THR_W-1:0]      w_top;
    logic [THR_W-1:0]      w_span;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [PROD_W-1:0]     w_quotient;
    logic                  w_brake;
    logic [CUR_W-1:0]      w_cmd;
    logic [DISP_W-1:0]     w_mag;
    logic [KIND_W-1:0]     w_kind;

    dca_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    dca_divider #(
        .DIVIDEND_W (PROD_W),
        .DIVISOR_W  (THR_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod),
        .i_divisor  (w_span),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_out_take  = r_out_valid && !i_out_stall;
    assign w_load_out  = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);
    assign w_div_start = (r_state == S_DIV_GO);

    always_comb begin
        w_sum       = {1'b0, r_timer} + (TIMER_BITS + 1)'(i_elapsed_ms);
        w_timer_sat = w_sum[TIMER_BITS] ? '1 : w_sum[TIMER_BITS-1:0];
        w_dm_edge   = i_dead_man_pressed && !r_dm_prev;
        w_timer_a   = w_dm_edge ? '0 : w_timer_sat;
        w_il_a      = w_dm_edge ? 1'b1 : r_interlock;
        w_at_zero   = (i_throttle_raw <= w_cfg.thr_zero_pt);
        if (w_at_zero) begin
            n_timer     = w_timer_a;
            n_interlock = w_il_a &&
                          !(CMP_W'(w_timer_a) > CMP_W'(w_cfg.interlock_ms));
        end else begin
            n_timer     = '0;
            n_interlock = w_il_a;
        end
        w_span_ok = !w_at_zero && (w_cfg.thr_full_pt > w_cfg.thr_zero_pt);
    end

    always_comb begin
        w_top  = (r_raw < w_cfg.thr_full_pt) ? r_raw : w_cfg.thr_full_pt;
        w_span = w_cfg.thr_full_pt - w_cfg.thr_zero_pt;
    end

    always_comb begin
        w_cmd   = '0;
        w_brake = 1'b0;
        if (r_active) begin
            w_brake = 1'b1;
            if (r_brk) begin
                w_cmd = w_cfg.brake_hold_ma;
            end else if (r_dm) begin
                if (r_drive != '0) begin
                    w_cmd   = r_drive;
                    w_brake = 1'b0;
                end else begin
                    w_cmd = w_cfg.coast_hold_ma;
                end
            end else begin
                w_cmd = w_cfg.stop_hold_ma;
            end
            if (!r_batt || r_interlock) begin
                w_cmd   = '0;
                w_brake = 1'b0;
            end
        end
        w_mag = {1'b0, w_cmd};
        case (r_slot)
            SLOT_M1:     w_kind = w_brake ? KIND_M1_BRAKE : KIND_M1_CURRENT;
            SLOT_M2:     w_kind = w_brake ? KIND_M2_BRAKE : KIND_M2_CURRENT;
            SLOT_TELE_1: w_kind = KIND_M1_TELEMETRY;
            default:     w_kind = KIND_M2_TELEMETRY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_dm_prev   <= 1'b0;
            r_interlock <= 1'b1;
            r_timer     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_take && !w_load_out) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_timer     <= n_timer;
                        r_interlock <= n_interlock;
                        r_dm_prev   <= i_dead_man_pressed;
                        r_state     <= w_span_ok ? S_MUL : S_FINISH;
                    end
                end
                S_MUL: begin
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_load_out) begin
                        r_out_valid <= 1'b1;
                        r_slot      <= r_slot + 2'd1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_raw    <= i_throttle_raw;
            r_dm     <= i_dead_man_pressed;
            r_brk    <= i_brake_pressed;
            r_active <= i_drive_active;
            r_batt   <= i_battery_ok;
            r_drive  <= '0;
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(w_top - w_cfg.thr_zero_pt) * PROD_W'(w_cfg.drive_full_ma);
        end
        if (r_state == S_DIV_WAIT && w_div_done) begin
            r_drive <= w_quotient[CUR_W-1:0];
        end
        if (w_load_out) begin
            r_kind   <= w_kind;
            r_cmd    <= w_cmd;
            r_disp   <= w_brake ? (DISP_W'(0) - w_mag) : w_mag;
            r_il_out <= r_interlock;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_packet_kind      = r_kind;
    assign o_command_ma       = r_cmd;
    assign o_display_ma       = r_disp;
    assign o_interlock_active = r_il_out;

    a_interlock_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_interlock_active |-> o_command_ma == '0)
        else $error("interlock active with nonzero command");

    a_disp_magnitude: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_display_ma[DISP_W-1] |-> o_display_ma[CUR_W-1:0] == o_command_ma)
        else $error("display does not match command");

    a_disp_negated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_display_ma[DISP_W-1]
        |-> (DISP_W'(0) - o_display_ma) == {1'b0, o_command_ma})
        else $error("braking display is not the negated command");

    a_slot_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> r_slot == ($past(r_slot) + 2'd1))
        else $error("slot did not advance by one per packet");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV_WAIT)
        else $error("divider finished outside the wait state");

endmodule
